// File: src/css_pkg.sv
// package for the cpu scheduler: policy codes, op codes, cell types
// no dependencies
package css_pkg;

   localparam logic [1:0] POLICY_FCFS     = 2'd0;
   localparam logic [1:0] POLICY_SPN      = 2'd1;
   localparam logic [1:0] POLICY_RR       = 2'd2;
   // unused code, runs as fcfs
   localparam logic [1:0] POLICY_RESERVED = 2'd3;

   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic CSR_POLICY  = 1'b0;
   localparam logic CSR_QUANTUM = 1'b1;

   localparam logic [15:0] TIME_MAX = 16'hFFFF;

   // queue entry carried along the chain: service key for sorted insert
   typedef struct packed {
      logic        valid;
      logic [15:0] key;
   } cell_info_type;

   // shift command broadcast to every queue cell
   typedef struct packed {
      logic        pop;
      logic        push;
      logic        sorted;
      logic [15:0] key;
   } queue_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

endpackage

// File: src/css_cell.sv
// one ready queue cell: holds a slot number and its service key
// depends on css_pkg
module css_cell #(
   parameter int SLOT_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  css_pkg::queue_cmd_type cmd,
   input  logic [SLOT_W-1:0]      new_slot,
   input  css_pkg::cell_info_type prev_info,
   input  logic [SLOT_W-1:0]      prev_slot,
   input  logic                   prev_insert,
   input  css_pkg::cell_info_type next_info,
   input  logic [SLOT_W-1:0]      next_slot,
   output css_pkg::cell_info_type info,
   output logic [SLOT_W-1:0]      slot,
   output logic                   insert_here
);
   logic              valid_ff, valid_in;
   logic [15:0]       key_ff, key_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              goes_after;

   assign info.valid = valid_ff;
   assign info.key   = key_ff;
   assign slot       = slot_ff;

   // new entry lands at the first empty cell or, if sorted, the first cell with a larger key
   assign goes_after  = !prev_insert && valid_ff && (!cmd.sorted || key_ff <= cmd.key);
   assign insert_here = !goes_after;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      slot_in  = slot_ff;
      if (cmd.pop) begin
         valid_in = next_info.valid;
         key_in   = next_info.key;
         slot_in  = next_slot;
      end else if (cmd.push && insert_here) begin
         if (prev_insert) begin
            // shift right from the neighbor
            valid_in = prev_info.valid;
            key_in   = prev_info.key;
            slot_in  = prev_slot;
         end else begin
            valid_in = 1'b1;
            key_in   = cmd.key;
            slot_in  = new_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff  <= key_in;
      slot_ff <= slot_in;
   end
endmodule

// File: src/css_queue.sv
// ready queue as a chain of cells, head at cell zero
// depends on css_pkg, css_cell
module css_queue #(
   parameter int SLOTS  = 16,
   parameter int SLOT_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  css_pkg::queue_cmd_type cmd,
   input  logic [SLOT_W-1:0]      new_slot,
   output logic                   head_valid,
   output logic [SLOT_W-1:0]      head_slot
);
   css_pkg::cell_info_type info [SLOTS+1];
   logic [SLOT_W-1:0]      slots [SLOTS+1];
   logic                   ins [SLOTS];

   assign info[SLOTS].valid = 1'b0;
   assign info[SLOTS].key   = '0;
   assign slots[SLOTS]      = '0;

   genvar i;
   generate
      for (i = 0; i < SLOTS; i++) begin : g_cell
         css_cell #(.SLOT_W(SLOT_W)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .new_slot    (new_slot),
            .prev_info   ((i == 0) ? info[SLOTS] : info[(i == 0) ? 0 : i-1]),
            .prev_slot   (slots[(i == 0) ? SLOTS : i-1]),
            .prev_insert ((i == 0) ? 1'b0 : ins[(i == 0) ? 0 : i-1]),
            .next_info   (info[i+1]),
            .next_slot   (slots[i+1]),
            .info        (info[i]),
            .slot        (slots[i]),
            .insert_here (ins[i])
         );
      end
   endgenerate

   assign head_valid = info[0].valid;
   assign head_slot  = slots[0];
endmodule

// File: src/cpu_scheduler_fcfs_spn_rr.sv
// cpu scheduler, fcfs / spn / round robin, top level
// uses css_pkg and css_queue (a chain of queue cells)
// A request is accepted in ST_IDLE; in ST_EXEC the tick or arrival runs
// against the slot table and issues a queue command (the queue cells shift
// at its closing edge); in ST_OUT the response is presented. A round robin
// requeue holds the response back while the tail push, registered in rq_ff,
// is issued after the pop. The next request is accepted only once the
// response leaves, so a stalled response holds off the input too. The ready
// queue is a row of cells, each holding one slot number and its service key;
// a sorted insert finds its place by comparing along the chain, and all
// cells shift together. No clearing pass.
module cpu_scheduler_fcfs_spn_rr #(
   parameter int PROC_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_proc_id,
   input  logic [15:0] req_service_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_now_time,
   output logic        rsp_accepted,
   output logic        rsp_cpu_busy,
   output logic [7:0]  rsp_running_id,
   output logic        rsp_done_valid,
   output logic [7:0]  rsp_done_id,
   output logic [15:0] rsp_response_time,
   output logic [15:0] rsp_wait_time,
   output logic [15:0] rsp_turnaround_time,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);
   localparam int SLOT_W = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;

   css_pkg::state_type state_ff, state_in;

   logic [1:0]        policy_ff;
   logic [7:0]        quantum_ff;
   logic [PROC_SLOTS-1:0] used_ff, used_in, started_ff, started_in;
   logic [7:0]        pid_mem   [PROC_SLOTS];
   logic [15:0]       arr_mem   [PROC_SLOTS];
   logic [15:0]       svc_mem   [PROC_SLOTS];
   logic [15:0]       rem_mem   [PROC_SLOTS];
   logic [15:0]       start_mem [PROC_SLOTS];
   logic [SLOT_W-1:0] run_slot_ff, run_slot_in;
   logic              run_valid_ff, run_valid_in;
   logic [7:0]        qleft_ff, qleft_in;
   logic [15:0]       time_ff, time_in;

   logic              op_ff;
   logic [7:0]        pid_ff;
   logic [15:0]       svc_ff;

   logic [15:0] now_ff, now_in, resp_ff, resp_in, wait_ff, wait_in, turn_ff, turn_in;
   logic        acc_ff, acc_in, busy_ff, busy_in, done_ff, done_in;
   logic [7:0]  rid_ff, rid_in, did_ff, did_in;

   css_pkg::queue_cmd_type cmd;
   logic [SLOT_W-1:0] new_slot;
   logic              head_valid;
   logic [SLOT_W-1:0] head_slot;

   // rr requeue is issued the cycle after execute, while the response waits
   logic              rq_ff;
   logic [SLOT_W-1:0] rq_slot_ff;
   css_pkg::queue_cmd_type cmd_q;
   logic [SLOT_W-1:0] new_slot_q;

   // lowest free slot
   logic              free_found;
   logic [SLOT_W-1:0] free_slot;
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = PROC_SLOTS-1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   css_queue #(.SLOTS(PROC_SLOTS), .SLOT_W(SLOT_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd_q),
      .new_slot   (new_slot_q),
      .head_valid (head_valid),
      .head_slot  (head_slot)
   );

   // execute-stage datapath
   logic              dispatch;
   logic [SLOT_W-1:0] s;
   logic [15:0]       rem_s, start_s, turn, time_run;
   logic              do_finish, do_run, requeue;
   logic [7:0]        qnext;
   logic              rem_wr, start_wr, arr_wr;
   logic [15:0]       rem_wdata;

   always_comb begin
      dispatch  = !run_valid_ff && head_valid;
      s         = dispatch ? head_slot : run_slot_ff;
      rem_s     = rem_mem[s];
      start_s   = (dispatch && !started_ff[s]) ? time_ff : start_mem[s];
      qnext     = qleft_ff;
      if (dispatch && policy_ff == css_pkg::POLICY_RR) begin
         qnext = (quantum_ff == 8'd0) ? 8'd1 : quantum_ff;
      end
      do_run    = (run_valid_ff || dispatch) && rem_s != 16'd0;
      time_run  = (time_ff != css_pkg::TIME_MAX) ? time_ff + 16'd1 : time_ff;
      do_finish = (run_valid_ff || dispatch) && (rem_s == 16'd0 || rem_s == 16'd1);
      if (do_run && policy_ff == css_pkg::POLICY_RR && qnext != 8'd0) begin
         qnext = qnext - 8'd1;
      end
      requeue   = do_run && !do_finish && policy_ff == css_pkg::POLICY_RR && qnext == 8'd0;
      turn      = (do_run ? time_run : time_ff) > arr_mem[s] ?
                  (do_run ? time_run : time_ff) - arr_mem[s] : 16'd0;
   end

   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      started_in  = started_ff;
      run_slot_in = run_slot_ff;
      run_valid_in = run_valid_ff;
      qleft_in    = qleft_ff;
      time_in     = time_ff;
      cmd         = '0;
      new_slot    = free_slot;
      rem_wr      = 1'b0;
      start_wr    = 1'b0;
      arr_wr      = 1'b0;
      rem_wdata   = rem_s - 16'd1;
      now_in  = now_ff;  acc_in  = acc_ff;  busy_in = busy_ff; rid_in = rid_ff;
      done_in = done_ff; did_in  = did_ff;  resp_in = resp_ff;
      wait_in = wait_ff; turn_in = turn_ff;
      unique case (state_ff)
         css_pkg::ST_IDLE: begin
            if (req_valid) state_in = css_pkg::ST_EXEC;
         end
         css_pkg::ST_EXEC: begin
            state_in = css_pkg::ST_OUT;
            busy_in = 1'b0; rid_in = '0; done_in = 1'b0; did_in = '0;
            resp_in = '0; wait_in = '0; turn_in = '0;
            if (op_ff == css_pkg::OP_ARRIVE) begin
               now_in = time_ff;
               acc_in = free_found;
               if (free_found) begin
                  used_in[free_slot]    = 1'b1;
                  started_in[free_slot] = 1'b0;
                  arr_wr     = 1'b1;
                  cmd.push   = 1'b1;
                  cmd.sorted = (policy_ff == css_pkg::POLICY_SPN);
                  cmd.key    = svc_ff;
               end
            end else begin
               acc_in = 1'b1;
               if (dispatch) begin
                  cmd.pop      = 1'b1;
                  run_slot_in  = head_slot;
                  run_valid_in = 1'b1;
                  qleft_in     = qnext;
                  if (!started_ff[head_slot]) begin
                     started_in[head_slot] = 1'b1;
                     start_wr = 1'b1;
                  end
               end
               time_in = time_run;
               if (do_run) begin
                  rem_wr  = 1'b1;
                  busy_in = 1'b1;
                  rid_in  = pid_mem[s];
                  qleft_in = qnext;
               end
               if (do_finish) begin
                  done_in = 1'b1;
                  did_in  = pid_mem[s];
                  resp_in = start_s > arr_mem[s] ? start_s - arr_mem[s] : 16'd0;
                  turn_in = turn;
                  wait_in = turn > svc_mem[s] ? turn - svc_mem[s] : 16'd0;
                  used_in[s]    = 1'b0;
                  started_in[s] = 1'b0;
                  run_valid_in  = 1'b0;
               end else if (requeue) begin
                  // pop and push cannot share the cycle; requeue goes next cycle
                  run_valid_in = 1'b0;
               end
               now_in = time_run;
            end
         end
         css_pkg::ST_OUT: begin
            if (!rsp_stall && !rq_ff) state_in = css_pkg::ST_IDLE;
         end
         default: state_in = css_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_q      = cmd;
      new_slot_q = new_slot;
      if (rq_ff) begin
         cmd_q.push   = 1'b1;
         cmd_q.sorted = 1'b0;
         // keep the real service as key in case the policy later turns to spn
         cmd_q.key    = svc_mem[rq_slot_ff];
         new_slot_q   = rq_slot_ff;
      end
   end

   assign req_stall = (state_ff != css_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == css_pkg::ST_OUT) && !rq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= css_pkg::ST_IDLE;
         policy_ff    <= css_pkg::POLICY_FCFS;
         quantum_ff   <= 8'd4;
         used_ff      <= '0;
         started_ff   <= '0;
         run_slot_ff  <= '0;
         run_valid_ff <= 1'b0;
         qleft_ff     <= '0;
         time_ff      <= '0;
         rq_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         started_ff   <= started_in;
         run_slot_ff  <= run_slot_in;
         run_valid_ff <= run_valid_in;
         qleft_ff     <= qleft_in;
         time_ff      <= time_in;
         rq_ff        <= (state_ff == css_pkg::ST_EXEC) && op_ff == css_pkg::OP_TICK
                         && requeue;
         if (csr_write) begin
            case (csr_index)
               css_pkg::CSR_POLICY:  policy_ff  <= csr_data[1:0];
               css_pkg::CSR_QUANTUM: quantum_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == css_pkg::ST_IDLE && req_valid) begin
         op_ff  <= req_op;
         pid_ff <= req_proc_id;
         svc_ff <= req_service_time;
      end
      if (state_ff == css_pkg::ST_EXEC && requeue && op_ff == css_pkg::OP_TICK) begin
         rq_slot_ff <= s;
      end
      if (state_ff == css_pkg::ST_EXEC) begin
         if (arr_wr) begin
            pid_mem[free_slot] <= pid_ff;
            arr_mem[free_slot] <= time_ff;
            svc_mem[free_slot] <= svc_ff;
            rem_mem[free_slot] <= svc_ff;
         end
         if (rem_wr)   rem_mem[s] <= rem_wdata;
         if (start_wr) start_mem[head_slot] <= time_ff;
      end
      now_ff <= now_in; acc_ff <= acc_in; busy_ff <= busy_in; rid_ff <= rid_in;
      done_ff <= done_in; did_ff <= did_in; resp_ff <= resp_in;
      wait_ff <= wait_in; turn_ff <= turn_in;
   end

   assign rsp_now_time        = now_ff;
   assign rsp_accepted        = acc_ff;
   assign rsp_cpu_busy        = busy_ff;
   assign rsp_running_id      = rid_ff;
   assign rsp_done_valid      = done_ff;
   assign rsp_done_id         = did_ff;
   assign rsp_response_time   = resp_ff;
   assign rsp_wait_time       = wait_ff;
   assign rsp_turnaround_time = turn_ff;
endmodule

// File: src/css_checker.sv
// port-level checker for the cpu scheduler, bound to the top level
// depends on cpu_scheduler_fcfs_spn_rr ports only
module css_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_accepted,
   input logic        rsp_cpu_busy,
   input logic        rsp_done_valid,
   input logic [7:0]  rsp_running_id,
   input logic [15:0] rsp_now_time
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_now_time))
      else $error("response dropped while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   a_busy_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_cpu_busy || rsp_done_valid) |-> rsp_accepted)
      else $error("busy or done on rejected arrival");

   a_idle_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cpu_busy |-> rsp_running_id == 8'd0)
      else $error("running id set while idle");

   a_accept_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken before response");
endmodule

bind cpu_scheduler_fcfs_spn_rr css_checker u_css_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_accepted   (rsp_accepted),
   .rsp_cpu_busy   (rsp_cpu_busy),
   .rsp_done_valid (rsp_done_valid),
   .rsp_running_id (rsp_running_id),
   .rsp_now_time   (rsp_now_time)
);
